### hw/rtl/rbyv_pkg.sv
package rbyv_pkg;

  // Sample kind carried in tuser
  typedef enum logic [1:0] {
    KIND_LUMA = 2'd0,
    KIND_CB   = 2'd1,
    KIND_CR   = 2'd2
  } kind_e;

  // Mode code that a config write may not select
  localparam logic [2:0] REFUSED_MODE = 3'd5;

  // Luma = (2R + 4G + B + 3) / 7, done as a reciprocal multiply.
  // 2341 / 2^14 is exact for numerators below 5461; ours stay below 1789.
  localparam logic [11:0] LUMA_RECIP = 12'd2341;
  localparam logic [1:0]  LUMA_ROUND = 2'd3;

  // Block geometry of one mode
  typedef struct packed {
    logic [2:0] width;
    logic [2:0] height;
    logic [2:0] chroma;        // chroma samples per component
    logic [2:0] rows_per_grp;  // block rows per chroma group
  } mode_geom_t;

  // One result word as it leaves the block
  typedef struct packed {
    logic [8:0] sample;
    kind_e      kind;
    logic [4:0] index;
    logic       last;
  } res_t;

  function automatic mode_geom_t mode_geom(logic [2:0] mode);
    mode_geom_t g;
    unique case (mode)
      3'd0:    g = '{width: 3'd4, height: 3'd4, chroma: 3'd1, rows_per_grp: 3'd4};
      3'd1:    g = '{width: 3'd4, height: 3'd4, chroma: 3'd4, rows_per_grp: 3'd1};
      3'd2:    g = '{width: 3'd4, height: 3'd3, chroma: 3'd1, rows_per_grp: 3'd3};
      3'd3:    g = '{width: 3'd4, height: 3'd3, chroma: 3'd3, rows_per_grp: 3'd1};
      3'd4:    g = '{width: 3'd3, height: 3'd3, chroma: 3'd1, rows_per_grp: 3'd3};
      3'd5:    g = '{width: 3'd3, height: 3'd3, chroma: 3'd2, rows_per_grp: 3'd1};
      3'd6:    g = '{width: 3'd4, height: 3'd2, chroma: 3'd1, rows_per_grp: 3'd2};
      default: g = '{width: 3'd4, height: 3'd2, chroma: 3'd2, rows_per_grp: 3'd1};
    endcase
    return g;
  endfunction

  // Luma of one pixel, clipped to 255
  function automatic logic [7:0] luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [10:0] num;
    logic [22:0] prod;
    num  = {2'b0, r, 1'b0} + {1'b0, g, 2'b0} + {3'b0, b} + {9'b0, LUMA_ROUND};
    prod = 23'(num) * 23'(LUMA_RECIP);
    return (prod[22]) ? 8'hFF : prod[21:14];
  endfunction

  // Group sum / (2 * width * rows_per_grp), rounded half away from zero,
  // clipped to -128..127. Divisors are 32, 8, 24, 8, 18, 6, 16, 8 by mode.
  function automatic logic [8:0] chroma_value(logic signed [12:0] acc, logic [2:0] mode);
    logic        neg;
    logic [12:0] mag_abs;
    logic [12:0] half;
    logic [12:0] mag;
    logic [19:0] p24;
    logic [22:0] p18;
    logic [22:0] p6;
    logic [9:0]  q;
    logic [8:0]  res;
    neg     = acc[12];
    mag_abs = neg ? 13'(-acc) : 13'(acc);
    unique case (mode)
      3'd0:          half = 13'd16;
      3'd2:          half = 13'd12;
      3'd4:          half = 13'd9;
      3'd5:          half = 13'd3;
      3'd6:          half = 13'd8;
      default:       half = 13'd4;
    endcase
    mag = mag_abs + half;
    // divide by 3 via 683/2^11, by 9 via 1821/2^14
    p24 = 20'(mag[12:3]) * 20'd683;
    p18 = 23'(mag[12:1]) * 23'd1821;
    p6  = 23'(mag[12:1]) * 23'd683;
    unique case (mode)
      3'd0:    q = {2'b0, mag[12:5]};
      3'd2:    q = {1'b0, p24[19:11]};
      3'd4:    q = {1'b0, p18[22:14]};
      3'd5:    q = p6[20:11];
      3'd6:    q = {1'b0, mag[12:4]};
      default: q = mag[12:3];
    endcase
    if (!neg) begin
      res = (q > 10'd127) ? 9'd127 : q[8:0];
    end else begin
      res = (q > 10'd128) ? 9'h180 : 9'(-q);
    end
    return res;
  endfunction

endpackage

### hw/rtl/rgb_block_to_ycc_vector_core.sv
// RGB block to luma/chroma vector converter.
// Pixels enter on the s_axis channel in raster order within a block; the
// block geometry comes from block_mode, written on the cfg channel; the user
// must write it only while the block is idle, which the block does not enforce
// (a write of mode 5 is ignored; any other write also restarts the block).
// Every pixel yields one luma sample, written to the result queue in the cycle
// of its transfer. After the last pixel of a block the block emits its Cb
// samples, then its Cr samples, one per cycle while the result queue has
// room, tlast on the final Cr. Throughput: one pixel per cycle inside a block
// while the result queue is not full. At each block end the input is held off
// while the last pixel is accumulated and while the single chroma divide/clip
// unit walks the group sums, one chroma sample (2 to 8) at a time.
// A two-entry result queue sits in front of m_axis, so a pixel is taken while
// one result waits; when the receiver stalls and the queue fills, s_axis
// tready drops and the chroma walk pauses. Nothing is lost.
// Reset: block_mode = 7, block position and group sums cleared, queue empty.
module rgb_block_to_ycc_vector_core
  import rbyv_pkg::*;
#(
  parameter int unsigned MAX_CHROMA_GROUPS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,      // block_mode
  // pixel input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // red [7:0], green [15:8], blue [23:16]
  // sample output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // sample [8:0], element_index [13:9], zero [15:14]
  output logic [1:0]  m_axis_tuser_o,  // sample_kind [1:0]
  output logic        m_axis_tlast_o   // vector_end
);

  localparam int unsigned GW = (MAX_CHROMA_GROUPS > 1) ? $clog2(MAX_CHROMA_GROUPS) : 1;
  localparam logic [2:0] GRP_MAX = 3'(MAX_CHROMA_GROUPS - 1);

  logic [2:0]  mode_q;
  mode_geom_t  geom;
  logic [1:0]  col_q, row_q;
  logic signed [12:0] blue_sum_q [MAX_CHROMA_GROUPS];
  logic signed [12:0] red_sum_q  [MAX_CHROMA_GROUPS];

  // pixel stage feeding the accumulators
  logic          p_valid_q, p_last_q;
  logic [7:0]    p_y_q, p_r_q, p_b_q;
  logic [GW-1:0] p_grp_q;

  // chroma walk
  logic          drain_q, phase_q;
  logic [GW-1:0] dk_q;

  // result queue
  res_t        fifo_q [2];
  logic [1:0]  cnt_q;
  logic        wr_ptr_q, rd_ptr_q;

  logic        cfg_set, in_fire, pop, push, drain_push;
  logic [7:0]  in_r, in_g, in_b, in_y;
  logic        col_last, row_last, blk_last;
  logic [2:0]  grp_raw, grp_sel;
  logic [4:0]  luma_idx, chroma_base, dindex;
  logic [2:0]  emitted_m1;
  logic        dlast_grp, dend, drain_done;
  logic signed [12:0] dsum;
  logic signed [12:0] diff_b, diff_r;
  res_t        push_data;

  assign geom = mode_geom(mode_q);

  // handshakes
  assign cfg_ready_o     = 1'b1;
  assign cfg_set         = cfg_valid_i && (cfg_data_i != REFUSED_MODE);
  assign s_axis_tready_o = !drain_q && !(p_valid_q && p_last_q) && (cnt_q != 2'd2);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;

  // pixel decode and luma
  assign in_r = s_axis_tdata_i[7:0];
  assign in_g = s_axis_tdata_i[15:8];
  assign in_b = s_axis_tdata_i[23:16];
  assign in_y = luma(in_r, in_g, in_b);

  assign col_last = ({1'b0, col_q} == (geom.width - 3'd1));
  assign row_last = ({1'b0, row_q} == (geom.height - 3'd1));
  assign blk_last = col_last && row_last;
  assign luma_idx = 5'({3'b0, row_q} * {2'b0, geom.width}) + {3'b0, col_q};

  // chroma group of the current row
  always_comb begin
    case (geom.rows_per_grp)
      3'd1:    grp_raw = {1'b0, row_q};
      3'd2:    grp_raw = {2'b0, row_q[1]};
      3'd3:    grp_raw = (row_q == 2'd3) ? 3'd1 : 3'd0;
      default: grp_raw = 3'd0;
    endcase
    grp_sel = (grp_raw > GRP_MAX) ? GRP_MAX : grp_raw;
  end

  // chroma walk datapath
  assign emitted_m1  = ((geom.chroma - 3'd1) > GRP_MAX) ? GRP_MAX : (geom.chroma - 3'd1);
  assign chroma_base = 5'({2'b0, geom.width} * {2'b0, geom.height});
  assign dsum        = phase_q ? red_sum_q[dk_q] : blue_sum_q[dk_q];
  assign dlast_grp   = (3'(dk_q) == emitted_m1);
  assign dend        = phase_q && dlast_grp;
  assign dindex      = chroma_base + (phase_q ? (5'(emitted_m1) + 5'd1) : 5'd0) + 5'(dk_q);
  assign drain_push  = drain_q && (cnt_q != 2'd2);
  assign drain_done  = drain_push && dend;

  // queue write mux: luma on a pixel transfer, chroma while walking
  always_comb begin
    if (drain_q) begin
      push_data.sample = chroma_value(dsum, mode_q);
      push_data.kind   = phase_q ? KIND_CR : KIND_CB;
      push_data.index  = dindex;
      push_data.last   = dend;
    end else begin
      push_data.sample = {1'b0, in_y};
      push_data.kind   = KIND_LUMA;
      push_data.index  = luma_idx;
      push_data.last   = 1'b0;
    end
  end
  assign push = in_fire || drain_push;

  // mode register and block position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 3'd7;
      col_q  <= 2'd0;
      row_q  <= 2'd0;
    end else if (cfg_set) begin
      mode_q <= cfg_data_i;
      col_q  <= 2'd0;
      row_q  <= 2'd0;
    end else if (in_fire) begin
      if (blk_last) begin
        col_q <= 2'd0;
        row_q <= 2'd0;
      end else if (col_last) begin
        col_q <= 2'd0;
        row_q <= row_q + 2'd1;
      end else begin
        col_q <= col_q + 2'd1;
      end
    end
  end

  // pixel stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_last_q  <= 1'b0;
    end else begin
      p_valid_q <= in_fire;
      p_last_q  <= in_fire && blk_last;
    end
  end

  // pixel stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      p_y_q   <= in_y;
      p_r_q   <= in_r;
      p_b_q   <= in_b;
      p_grp_q <= GW'(grp_sel);
    end
  end

  // group sums
  assign diff_b = $signed({5'b0, p_b_q}) - $signed({5'b0, p_y_q});
  assign diff_r = $signed({5'b0, p_r_q}) - $signed({5'b0, p_y_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < MAX_CHROMA_GROUPS; g++) begin
        blue_sum_q[g] <= '0;
        red_sum_q[g]  <= '0;
      end
    end else if (cfg_set || drain_done) begin
      for (int g = 0; g < MAX_CHROMA_GROUPS; g++) begin
        blue_sum_q[g] <= '0;
        red_sum_q[g]  <= '0;
      end
    end else if (p_valid_q) begin
      blue_sum_q[p_grp_q] <= blue_sum_q[p_grp_q] + diff_b;
      red_sum_q[p_grp_q]  <= red_sum_q[p_grp_q] + diff_r;
    end
  end

  // chroma walk sequencer: all Cb groups, then all Cr groups
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      phase_q <= 1'b0;
      dk_q    <= '0;
    end else if (p_valid_q && p_last_q) begin
      drain_q <= 1'b1;
      phase_q <= 1'b0;
      dk_q    <= '0;
    end else if (drain_push) begin
      if (dlast_grp) begin
        dk_q <= '0;
        if (phase_q) begin
          drain_q <= 1'b0;
          phase_q <= 1'b0;
        end else begin
          phase_q <= 1'b1;
        end
      end else begin
        dk_q <= dk_q + GW'(1);
      end
    end
  end

  // result queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_data;
    end
  end

  // output
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {2'b00, fifo_q[rd_ptr_q].index, fifo_q[rd_ptr_q].sample};
  assign m_axis_tuser_o  = fifo_q[rd_ptr_q].kind;
  assign m_axis_tlast_o  = fifo_q[rd_ptr_q].last;

`ifndef SYNTHESIS
  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  // chroma walk starts only after a block's last pixel was accumulated
  a_drain_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(drain_q) |-> $past(p_valid_q && p_last_q))
    else $error("chroma walk started without block end");

  // no pixel taken while chroma samples are pending
  a_no_pixel_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_q || (p_valid_q && p_last_q)) |-> !in_fire)
    else $error("pixel accepted during block end");

  // vector end marks only a Cr sample
  a_last_is_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tuser_o == KIND_CR))
    else $error("vector end on a non-Cr sample");
`endif

endmodule
